// File: hdl/wrench_line_of_action_assert.svh
// ---------------------------------------------------------------------------
// Wrench line of action assertion macros
// Shared property forms for the port-level checker.
// ---------------------------------------------------------------------------
`ifndef WRENCH_LINE_OF_ACTION_ASSERT_SVH
`define WRENCH_LINE_OF_ACTION_ASSERT_SVH

// Same-cycle implication, off while reset is low.
`define WLOA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off while reset is low.
`define WLOA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define WLOA_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/wloa_pkg.sv
// ---------------------------------------------------------------------------
// wloa_pkg
// Widths, saturation limits and helpers of the wrench line of action block.
// ---------------------------------------------------------------------------
package wloa_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DW        = 32;
    localparam int HW        = 31;
    localparam int SQ_W      = 2 * DW - 1;
    localparam int FFW       = 64;
    localparam int CRW       = FFW + 1;
    localparam int MAGW      = FFW;
    localparam int NUMW      = MAGW + FRAC_BITS;
    localparam int QW        = DW + 1;
    localparam int RDW       = FFW + QW;
    localparam int H2W       = 2 * HW;
    localparam int NW        = H2W + 2 * DW - 2;
    localparam int OQW       = 2 * HW;
    localparam int ODW       = FFW + OQW;
    localparam int SQW       = HW;
    localparam int DEPTH     = OQW + SQW;
    localparam int INW       = 6 * DW;
    localparam int OUTW      = 7 * DW;
    localparam int NLANE_R   = 4;
    localparam int NLANE_O   = 3;

    localparam logic [HW-1:0] HALF_LEN_RST = HW'(65536);

    typedef logic signed [DW-1:0] t_word;

    localparam t_word SAT_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam t_word SAT_MIN = {1'b1, {(DW-1){1'b0}}};

    // Clamp a one-bit-grown sum back to the word range.
    function automatic t_word clamp_word(input logic signed [DW:0] v);
        if (v[DW] != v[DW-1]) begin
            return v[DW] ? SAT_MIN : SAT_MAX;
        end
        return v[DW-1:0];
    endfunction

    // Apply sign and saturation to a truncated quotient magnitude.
    function automatic t_word sat_quot(input logic [QW-1:0] q, input logic ovf,
                                       input logic neg);
        logic [QW-1:0] lim;
        logic [QW-1:0] nq;
        lim = neg ? (QW'(1) << (DW - 1)) : ((QW'(1) << (DW - 1)) - QW'(1));
        nq  = -q;
        if (ovf || (q > lim)) begin
            return neg ? SAT_MIN : SAT_MAX;
        end
        return neg ? nq[DW-1:0] : q[DW-1:0];
    endfunction

endpackage

// File: hdl/wrench_line_of_action.sv
// ---------------------------------------------------------------------------
// Wrench line of action
// Line of action endpoints and pitch of one force/torque sample per transfer.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream s_axis carries one sample per transfer: force x/y/z and
//   moment x/y/z, signed fixed point. Master stream m_axis returns exactly
//   one result per sample, in order: start and end points of the line of
//   action (closest point r minus/plus half length along the unit force)
//   and the pitch in tdata, and the zero force flag in tuser.
//   An input transfer passes through four front stages (capture, products,
//   sums, magnitudes), 62 restoring division steps for the squared offset
//   (the quotients of r and pitch take 33 of those steps in parallel), 31
//   square root steps, a saturation stage and the output register. One
//   sample per cycle is taken back to back unless the output stalls.
//   Half length is written through i_cfg_wr_en/i_cfg_wr_data while the
//   block is idle; reset sets it to 1.0 and empties the pipeline.
//   A stalled receiver holds the output register and freezes the whole
//   pipeline, so s_axis_tready drops until the result is taken.
// ---------------------------------------------------------------------------
module wrench_line_of_action
    import wloa_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  logic [HW-1:0]   i_cfg_wr_data,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // force_x, force_y, force_z, moment_x, moment_y, moment_z
    input  logic [INW-1:0]  s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // start_x, start_y, start_z, end_x, end_y, end_z, pitch
    output logic [OUTW-1:0] m_axis_tdata,
    // zero_force
    output logic            m_axis_tuser
);

    logic w_en;

    // Configuration and the squared half length.
    logic [HW-1:0]  r_half_length;
    logic [H2W-1:0] r_h2;

    // Front stages.
    logic          r1_v;
    t_word         r1_f [3];
    t_word         r1_m [3];
    logic          r2_v;
    logic [SQ_W-1:0] r2_sq [3];
    logic signed [2*DW-1:0] r2_fm [3][3];
    logic          r3_v;
    logic [FFW-1:0] r3_ff;
    logic signed [CRW-1:0] r3_cr [NLANE_R];
    logic [2*DW-1:0] r3_pp00 [3];
    logic [2*DW-1:0] r3_pp01 [3];
    logic [2*DW-1:0] r3_pp10 [3];
    logic [2*DW-1:0] r3_pp11 [3];
    logic [2:0]    r3_fneg;
    logic [2:0]    r2_fneg;

    // Step pipeline: index 0 is the last front stage.
    logic          r_v     [0:DEPTH];
    logic          r_zero  [0:DEPTH];
    logic [2:0]    r_fneg  [0:DEPTH];
    logic [FFW-1:0] r_ff   [0:OQW-1];
    logic [NUMW-1:0] r_rrem [0:QW-1][NLANE_R];
    logic [QW-1:0] r_rq    [0:DEPTH][NLANE_R];
    logic          r_rovf  [0:DEPTH][NLANE_R];
    logic          r_rneg  [0:DEPTH][NLANE_R];
    logic [NW-1:0] r_orem  [0:OQW-1][NLANE_O];
    logic [OQW-1:0] r_oq   [0:OQW][NLANE_O];
    logic [OQW-1:0] r_sx   [1:SQW-1][NLANE_O];
    logic [OQW-1:0] r_sres [1:SQW][NLANE_O];

    // Saturation stage and output register.
    logic          r_e_v;
    logic          r_e_zero;
    t_word         r_e_r   [NLANE_R];
    t_word         r_e_off [NLANE_O];
    logic          r_out_valid;
    logic [OUTW-1:0] r_out_data;
    logic          r_out_zero;
    logic [OUTW-1:0] n_out_data;

    // Advance everything unless a finished result is stuck at the output.
    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_length <= HALF_LEN_RST;
        end else if (i_cfg_wr_en) begin
            r_half_length <= i_cfg_wr_data;
        end
    end

    // Settles in the cycle after a write; the user must write only while idle, which the block does not enforce.
    always_ff @(posedge i_clk) begin
        r_h2 <= r_half_length * r_half_length;
    end

    // Valid bits of the front stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v   <= 1'b0;
            r2_v   <= 1'b0;
            r3_v   <= 1'b0;
            r_v[0] <= 1'b0;
        end else if (w_en) begin
            r1_v   <= s_axis_tvalid;
            r2_v   <= r1_v;
            r3_v   <= r2_v;
            r_v[0] <= r3_v;
        end
    end

    // Front datapath: capture, products, sums and partial products, magnitudes.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                r1_f[i] <= s_axis_tdata[i*DW +: DW];
                r1_m[i] <= s_axis_tdata[(3+i)*DW +: DW];
            end
            for (int i = 0; i < 3; i++) begin
                logic signed [2*DW-1:0] sq;
                sq          = r1_f[i] * r1_f[i];
                r2_sq[i]   <= sq[SQ_W-1:0];
                r2_fneg[i] <= r1_f[i][DW-1];
                for (int j = 0; j < 3; j++) begin
                    r2_fm[i][j] <= r1_f[i] * r1_m[j];
                end
            end
            r3_ff   <= FFW'(r2_sq[0]) + FFW'(r2_sq[1]) + FFW'(r2_sq[2]);
            r3_fneg <= r2_fneg;
            r3_cr[0] <= CRW'(r2_fm[1][2]) - CRW'(r2_fm[2][1]);
            r3_cr[1] <= CRW'(r2_fm[2][0]) - CRW'(r2_fm[0][2]);
            r3_cr[2] <= CRW'(r2_fm[0][1]) - CRW'(r2_fm[1][0]);
            r3_cr[3] <= CRW'(r2_fm[0][0]) + CRW'(r2_fm[1][1]) + CRW'(r2_fm[2][2]);
            // Split h^2 * F_i^2 into four narrow products.
            for (int i = 0; i < 3; i++) begin
                r3_pp00[i] <= (2*DW)'(r_h2[HW-1:0] * r2_sq[i][HW-1:0]);
                r3_pp01[i] <= (2*DW)'(r_h2[HW-1:0] * r2_sq[i][SQ_W-1:HW]);
                r3_pp10[i] <= (2*DW)'(r_h2[H2W-1:HW] * r2_sq[i][HW-1:0]);
                r3_pp11[i] <= (2*DW)'(r_h2[H2W-1:HW] * r2_sq[i][SQ_W-1:HW]);
            end
            r_zero[0] <= (r3_ff == '0);
            r_fneg[0] <= r3_fneg;
            r_ff[0]   <= r3_ff;
            for (int l = 0; l < NLANE_R; l++) begin
                logic signed [CRW-1:0] mag;
                mag = r3_cr[l][CRW-1] ? -r3_cr[l] : r3_cr[l];
                r_rrem[0][l] <= {mag[MAGW-1:0], {FRAC_BITS{1'b0}}};
                r_rneg[0][l] <= r3_cr[l][CRW-1];
                r_rq[0][l]   <= '0;
                r_rovf[0][l] <= 1'b0;
            end
            for (int l = 0; l < NLANE_O; l++) begin
                r_orem[0][l] <= (NW'(r3_pp11[l]) << (2 * HW))
                              + ((NW'(r3_pp01[l]) + NW'(r3_pp10[l])) << HW)
                              + NW'(r3_pp00[l]);
                r_oq[0][l]   <= '0;
            end
        end
    end

    genvar gs, gl;

    // Valid bits, zero flag and force signs ride along with every step.
    generate
        for (gs = 1; gs <= DEPTH; gs++) begin : g_side
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[gs] <= 1'b0;
                end else if (w_en) begin
                    r_v[gs] <= r_v[gs-1];
                end
            end
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_zero[gs] <= r_zero[gs-1];
                    r_fneg[gs] <= r_fneg[gs-1];
                end
            end
        end

        for (gs = 1; gs < OQW; gs++) begin : g_ff
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_ff[gs] <= r_ff[gs-1];
                end
            end
        end

        // Restoring division of r and pitch, one quotient bit per stage;
        // step one also flags quotients at or above 2^QW.
        for (gs = 1; gs <= DEPTH; gs++) begin : g_rstep
            for (gl = 0; gl < NLANE_R; gl++) begin : g_lane
                if (gs <= QW) begin : g_div
                    localparam int B = QW - gs;
                    logic [RDW-1:0] w_rem;
                    logic [RDW-1:0] w_d;
                    logic           w_ge;
                    logic           w_big;
                    assign w_rem = RDW'(r_rrem[gs-1][gl]);
                    assign w_d   = RDW'(r_ff[gs-1]) << B;
                    assign w_ge  = (w_rem >= w_d);
                    assign w_big = (gs == 1) && (w_rem >= {r_ff[gs-1], {QW{1'b0}}});
                    always_ff @(posedge i_clk) begin
                        if (w_en) begin
                            r_rq[gs][gl]   <= r_rq[gs-1][gl] | (QW'(w_ge) << B);
                            r_rovf[gs][gl] <= r_rovf[gs-1][gl] | w_big;
                            r_rneg[gs][gl] <= r_rneg[gs-1][gl];
                        end
                    end
                    if (gs < QW) begin : g_rem
                        always_ff @(posedge i_clk) begin
                            if (w_en) begin
                                r_rrem[gs][gl] <= w_ge ? NUMW'(w_rem - w_d)
                                                       : r_rrem[gs-1][gl];
                            end
                        end
                    end
                end else begin : g_hold
                    // Hold the quotient until the offset catches up.
                    always_ff @(posedge i_clk) begin
                        if (w_en) begin
                            r_rq[gs][gl]   <= r_rq[gs-1][gl];
                            r_rovf[gs][gl] <= r_rovf[gs-1][gl];
                            r_rneg[gs][gl] <= r_rneg[gs-1][gl];
                        end
                    end
                end
            end
        end

        // Offset: floor(h^2 F_i^2 / FF), below 2^OQW, one bit per stage.
        for (gs = 1; gs <= OQW; gs++) begin : g_ostep
            for (gl = 0; gl < NLANE_O; gl++) begin : g_lane
                localparam int B = OQW - gs;
                logic [ODW-1:0] w_rem;
                logic [ODW-1:0] w_d;
                logic           w_ge;
                assign w_rem = ODW'(r_orem[gs-1][gl]);
                assign w_d   = ODW'(r_ff[gs-1]) << B;
                assign w_ge  = (w_rem >= w_d);
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_oq[gs][gl] <= r_oq[gs-1][gl] | (OQW'(w_ge) << B);
                    end
                end
                if (gs < OQW) begin : g_rem
                    always_ff @(posedge i_clk) begin
                        if (w_en) begin
                            r_orem[gs][gl] <= w_ge ? NW'(w_rem - w_d) : r_orem[gs-1][gl];
                        end
                    end
                end
            end
        end

        // Integer square root, one result bit per stage.
        for (gs = 1; gs <= SQW; gs++) begin : g_sqrt
            for (gl = 0; gl < NLANE_O; gl++) begin : g_lane
                logic [OQW-1:0] w_px;
                logic [OQW-1:0] w_pr;
                logic [OQW-1:0] w_bit;
                logic [OQW:0]   w_sum;
                logic           w_ge;
                if (gs == 1) begin : g_in
                    assign w_px = r_oq[OQW][gl];
                    assign w_pr = '0;
                end else begin : g_mid
                    assign w_px = r_sx[gs-1][gl];
                    assign w_pr = r_sres[gs-1][gl];
                end
                assign w_bit = OQW'(1) << (2 * (SQW - gs));
                assign w_sum = {1'b0, w_pr} + {1'b0, w_bit};
                assign w_ge  = ({1'b0, w_px} >= w_sum);
                always_ff @(posedge i_clk) begin
                    if (w_en) begin
                        r_sres[gs][gl] <= w_ge ? ((w_pr >> 1) + w_bit) : (w_pr >> 1);
                    end
                end
                // The last step needs no remainder.
                if (gs < SQW) begin : g_x
                    always_ff @(posedge i_clk) begin
                        if (w_en) begin
                            r_sx[gs][gl] <= w_ge ? (w_px - w_sum[OQW-1:0]) : w_px;
                        end
                    end
                end
            end
        end
    endgenerate

    // Saturate r and pitch, sign the offsets.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_v <= 1'b0;
        end else if (w_en) begin
            r_e_v <= r_v[DEPTH];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_zero <= r_zero[DEPTH];
            for (int l = 0; l < NLANE_R; l++) begin
                r_e_r[l] <= sat_quot(r_rq[DEPTH][l], r_rovf[DEPTH][l], r_rneg[DEPTH][l]);
            end
            for (int l = 0; l < NLANE_O; l++) begin
                r_e_off[l] <= r_fneg[DEPTH][l] ? -t_word'(r_sres[SQW][l][DW-1:0])
                                               : t_word'(r_sres[SQW][l][DW-1:0]);
            end
        end
    end

    // Endpoints; drop everything to zero for a zero force.
    always_comb begin
        n_out_data = '0;
        if (!r_e_zero) begin
            for (int l = 0; l < 3; l++) begin
                n_out_data[l*DW +: DW]     = clamp_word((DW+1)'(r_e_r[l]) - (DW+1)'(r_e_off[l]));
                n_out_data[(3+l)*DW +: DW] = clamp_word((DW+1)'(r_e_r[l]) + (DW+1)'(r_e_off[l]));
            end
            n_out_data[6*DW +: DW] = r_e_r[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_e_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= n_out_data;
            r_out_zero <= r_e_zero;
        end
    end

endmodule

// File: hdl/wloa_chk.sv
// ---------------------------------------------------------------------------
// wloa_chk
// Port-level checks of the wrench line of action block, bound to the top.
// ---------------------------------------------------------------------------
`include "wrench_line_of_action_assert.svh"

module wloa_chk
    import wloa_pkg::*;
(
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            s_axis_tready,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [OUTW-1:0] m_axis_tdata,
    input logic            m_axis_tuser
);

    `WLOA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

    `WLOA_ASSERT_NOW(a_zero_clears, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "zero force result carries data")

    `WLOA_ASSERT_NOW(a_stall_blocks_in, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input taken while output stalled")

    `WLOA_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "result valid right after reset")

endmodule

bind wrench_line_of_action wloa_chk u_wloa_chk (.*);

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// Wrench line of action testbench
// Streams force/moment samples through the block with random gaps and stalls,
// predicts each line of action in exact wide integer arithmetic and compares
// every result field by field, in order.
// ----------------------------------------------------------------------------
module testbench
    import wloa_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY     = 98;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic signed [DW-1:0] mz, my, mx, fz, fy, fx;
    } sample_t;

    typedef struct {
        logic signed [DW-1:0] sx, sy, sz, ex, ey, ez, pitch;
        logic                 zf;
    } line_t;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_wr_en;
    logic [HW-1:0]   i_cfg_wr_data;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [INW-1:0]  s_axis_tdata;   // force_x, force_y, force_z, moment_x, moment_y, moment_z
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [OUTW-1:0] m_axis_tdata;   // start_x..z, end_x..z, pitch
    logic            m_axis_tuser;   // zero_force

    wrench_line_of_action dut (.*);

    sample_t   pending_samples[$];
    line_t     expected_lines[$];
    logic [HW-1:0] half_len;
    int        mismatches = 0;
    int        cycles = 0;
    int        gap_left;
    int        stall_left;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    // Integer square root, floor.
    function automatic logic [63:0] isqrt(input logic [63:0] x);
        logic [63:0] res, b;
        res = 0; b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [DW-1:0] clamp64(input logic signed [127:0] v);
        if (v > 128'sd2147483647) return 32'sh7fffffff;
        if (v < -128'sd2147483648) return 32'sh80000000;
        return v[DW-1:0];
    endfunction

    // Truncating signed quotient over a positive divisor; clamp64 saturates it afterwards.
    function automatic logic signed [127:0] trunc_div(input logic signed [127:0] n,
                                                      input logic [63:0] d);
        logic [127:0] mag;
        mag = (n < 0) ? -n : n;
        mag = mag / {64'd0, d};
        return (n < 0) ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic line_t predict_line(input sample_t s, input logic [HW-1:0] h);
        logic signed [127:0] f[3], m[3], cr[3], r[3], off[3], dot;
        logic [63:0] ff;
        logic [127:0] hf;
        line_t o;
        f[0] = s.fx; f[1] = s.fy; f[2] = s.fz;
        m[0] = s.mx; m[1] = s.my; m[2] = s.mz;
        ff = 64'(f[0] * f[0] + f[1] * f[1] + f[2] * f[2]);
        o = '{default: 0};
        if (ff == 0) begin
            o.zf = 1'b1;
            return o;
        end
        cr[0] = f[1] * m[2] - f[2] * m[1];
        cr[1] = f[2] * m[0] - f[0] * m[2];
        cr[2] = f[0] * m[1] - f[1] * m[0];
        dot   = f[0] * m[0] + f[1] * m[1] + f[2] * m[2];
        for (int i = 0; i < 3; i++) begin
            hf = {97'd0, h} * ((f[i] < 0) ? -f[i] : f[i]);
            hf = (hf[63:0] * hf[63:0]) / {64'd0, ff};
            off[i] = isqrt(hf[63:0]);
            if (f[i] < 0) off[i] = -off[i];
            r[i] = clamp64(trunc_div(cr[i] <<< FRAC_BITS, ff));
        end
        o.pitch = clamp64(trunc_div(dot <<< FRAC_BITS, ff));
        o.sx = clamp64(r[0] - off[0]); o.ex = clamp64(r[0] + off[0]);
        o.sy = clamp64(r[1] - off[1]); o.ey = clamp64(r[1] + off[1]);
        o.sz = clamp64(r[2] - off[2]); o.ez = clamp64(r[2] + off[2]);
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        mismatches++;
    endtask

    // Driver: hold each sample until its transfer, gaps drawn per sample.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            gap_left <= $urandom_range(0, 19);
        end else if (!s_axis_tvalid || s_axis_tready) begin
            // drop the sample that just transferred
            if (s_axis_tvalid) begin
                void'(pending_samples.pop_front());
            end
            if (gap_left > 0) begin
                s_axis_tvalid <= 1'b0;
                gap_left <= gap_left - 1;
            end else if (pending_samples.size() > 0) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_samples[0];
                expected_lines.insert(expected_lines.size(),
                                      predict_line(pending_samples[0], half_len));
                gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: stall the receiver at random and check each result transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_lines.size() == 0) begin
                    report_mismatch("unexpected result", m_axis_tdata[31:0], 0);
                end else begin
                    line_t w;
                    w = expected_lines.pop_front();
                    if (m_axis_tdata[0*DW +: DW] !== w.sx)
                        report_mismatch("start_x", m_axis_tdata[0*DW +: DW], w.sx);
                    if (m_axis_tdata[1*DW +: DW] !== w.sy)
                        report_mismatch("start_y", m_axis_tdata[1*DW +: DW], w.sy);
                    if (m_axis_tdata[2*DW +: DW] !== w.sz)
                        report_mismatch("start_z", m_axis_tdata[2*DW +: DW], w.sz);
                    if (m_axis_tdata[3*DW +: DW] !== w.ex)
                        report_mismatch("end_x", m_axis_tdata[3*DW +: DW], w.ex);
                    if (m_axis_tdata[4*DW +: DW] !== w.ey)
                        report_mismatch("end_y", m_axis_tdata[4*DW +: DW], w.ey);
                    if (m_axis_tdata[5*DW +: DW] !== w.ez)
                        report_mismatch("end_z", m_axis_tdata[5*DW +: DW], w.ez);
                    if (m_axis_tdata[6*DW +: DW] !== w.pitch)
                        report_mismatch("pitch", m_axis_tdata[6*DW +: DW], w.pitch);
                    if (m_axis_tuser !== w.zf)
                        report_mismatch("zero_force", 32'(m_axis_tuser), 32'(w.zf));
                end
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                m_axis_tready <= 1'b1;
                if (m_axis_tvalid && m_axis_tready)
                    stall_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 19);
            end
        end
    end

    // Cycle counter with a generous limit.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic logic signed [DW-1:0] rand_word();
        case ($urandom_range(0, 7))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 0;
            3: return $signed(32'($urandom_range(0, 16'hffff)) - 32'sd32768);
            4: return $signed(32'($urandom_range(0, 32'h3ffff)) - 32'sd131072) <<< 8;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_sample(input logic signed [DW-1:0] fx, fy, fz, mx, my, mz);
        sample_t s;
        s.fx = fx; s.fy = fy; s.fz = fz; s.mx = mx; s.my = my; s.mz = mz;
        pending_samples.insert(pending_samples.size(), s);
    endtask

    task automatic queue_random(input int count);
        logic signed [DW-1:0] a, b, c;
        for (int i = 0; i < count; i++) begin
            a = rand_word(); b = rand_word(); c = rand_word();
            if ($urandom_range(0, 15) == 0) begin a = 0; b = 0; c = 0; end
            queue_sample(a, b, c, rand_word(), rand_word(), rand_word());
        end
    endtask

    // Wait for the pipeline to drain, then rest for the latency.
    task automatic drain();
        while (pending_samples.size() > 0 || expected_lines.size() > 0 || s_axis_tvalid)
            @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    task automatic write_half_length(input logic [HW-1:0] value);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        half_len = value;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        logic [HW-1:0] settings[5];
        i_rst_n       <= 1'b0;
        i_cfg_wr_en   <= 1'b0;
        i_cfg_wr_data <= '0;
        half_len      = HALF_LEN_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero force, extremes, pure force, pure moment, sign corners.
        queue_sample(0, 0, 0, 32'sh7fffffff, 32'sh80000000, 123);
        queue_sample(0, 0, 0, 0, 0, 0);
        queue_sample(32'sh10000, 0, 0, 0, 32'sh10000, 0);
        queue_sample(0, 32'sh10000, 0, 32'sh10000, 32'sh20000, 32'sh30000);
        queue_sample(0, 0, -32'sh10000, 32'sh10000, 0, 32'sh50000);
        queue_sample(1, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff);
        queue_sample(1, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_sample(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
                     32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        queue_sample(32'sh80000000, 32'sh80000000, 32'sh80000000,
                     32'sh80000000, 32'sh80000000, 32'sh80000000);
        queue_sample(32'sh80000000, 1, -1, 1, 32'sh7fffffff, -1);
        queue_sample(-1, -1, -1, -1, -1, -1);
        queue_sample(3, -4, 12, 32'sh12345678, -32'sh0abcdef0, 32'sh00ff00ff);
        queue_random(8);
        drain();

        // Sweep the half length, extremes included.
        settings[0] = '0;
        settings[1] = {HW{1'b1}};
        settings[2] = HW'(1);
        settings[3] = HW'($urandom());
        settings[4] = HW'(32'h00030000);
        foreach (settings[k]) begin
            write_half_length(settings[k]);
            queue_random(165);
            drain();
        end

        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
